// ===== hw/rtl/lkc_pkg.sv =====
package lkc_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int STAMP_W  = 32;

  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;
  localparam logic [1:0] FUNC_NOP    = 2'd3;

  localparam logic [7:0] CFG_ENTRY_LIMIT = 8'd0;
  localparam logic [7:0] CFG_KEEP_DATA   = 8'd1;

  // Running summary handed from cell to cell during a sweep.
  typedef struct packed {
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic [DATA_W-1:0]  hit_data;
    logic               hit_cached;
    logic [CNT_W-1:0]   count;
    logic               free_found;
    logic [IDX_W-1:0]   free_idx;
    logic               cand_found;
    logic [IDX_W-1:0]   cand_idx;
    logic [STAMP_W-1:0] cand_stamp;
    logic [KEY_W-1:0]   cand_key;
  } tok_t;

  // Update broadcast to every cell at the end of a request.
  typedef struct packed {
    logic               clr_all;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    logic               inv_en;
    logic [IDX_W-1:0]   inv_idx;
    logic               touch_en;
    logic [IDX_W-1:0]   touch_idx;
    logic [KEY_W-1:0]   key;
    logic [DATA_W-1:0]  data;
    logic               cached;
    logic [STAMP_W-1:0] stamp;
  } upd_t;

endpackage

// ===== hw/rtl/lru_keyed_entry_cache_top.sv =====
// Channel  Handshake              Payload
// in       in_valid / in_ready    in_func, in_key_hash, in_entry_data
// out      out_valid / out_ready  out_hit, out_data_out, out_cached_mark,
//                                 out_evicted, out_evicted_hash, out_dup_error
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Lookup and insert: the request is accepted in idle, the summary token then walks
// the cell chain one cell per cycle during the sweep, and the done state applies the
// update and loads the result. Clear and no-op go from idle straight to done.
// Reset (rst_n low, synchronous) empties the cache and zeroes the stamp.
// in_ready is high only when idle; a finished request waits while the result
// register is full and out_ready is low.
module lru_keyed_entry_cache_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_key_hash,
  input  logic [31:0] in_entry_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic [31:0] out_data_out,
  output logic        out_cached_mark,
  output logic        out_evicted,
  output logic [31:0] out_evicted_hash,
  output logic        out_dup_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import lkc_pkg::*;

  logic [4:0]       entry_limit_r;
  logic             keep_data_r;
  logic [KEY_W-1:0] req_key;
  upd_t             upd;
  tok_t             tok [CAPACITY+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_limit_r <= 5'd16;
      keep_data_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_ENTRY_LIMIT) begin
        entry_limit_r <= cfg_data[4:0];
      end else if (cfg_index == CFG_KEEP_DATA) begin
        keep_data_r <= cfg_data[0];
      end
    end
  end

  lkc_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_key_hash      (in_key_hash),
    .in_entry_data    (in_entry_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hit          (out_hit),
    .out_data_out     (out_data_out),
    .out_cached_mark  (out_cached_mark),
    .out_evicted      (out_evicted),
    .out_evicted_hash (out_evicted_hash),
    .out_dup_error    (out_dup_error),
    .entry_limit      (entry_limit_r),
    .keep_data        (keep_data_r),
    .req_key          (req_key),
    .tok_init         (tok[0]),
    .tok_last         (tok[CAPACITY]),
    .upd              (upd)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    lkc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .req_key  (req_key),
      .upd      (upd),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1])
    );
  end

endmodule

// ===== hw/rtl/lkc_cell.sv =====
module lkc_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [lkc_pkg::IDX_W-1:0]  cell_idx,
  input  logic [lkc_pkg::KEY_W-1:0]  req_key,
  input  lkc_pkg::upd_t              upd,
  input  lkc_pkg::tok_t              tok_in,
  output lkc_pkg::tok_t              tok_out
);
  import lkc_pkg::*;

  logic               valid_r, valid_nxt;
  logic [KEY_W-1:0]   key_r;
  logic [DATA_W-1:0]  data_r;
  logic               cached_r;
  logic [STAMP_W-1:0] stamp_r;
  tok_t               tok_r, tok_nxt;
  logic               match;
  logic               older;

  assign match = valid_r && (key_r == req_key);
  assign older = valid_r && ((stamp_r < tok_in.cand_stamp) ||
                 (tok_in.cand_found && (stamp_r == tok_in.cand_stamp) &&
                  (key_r < tok_in.cand_key)));

  always_comb begin
    tok_nxt = tok_in;
    if (match && !tok_in.hit) begin
      tok_nxt.hit        = 1'b1;
      tok_nxt.hit_idx    = cell_idx;
      tok_nxt.hit_data   = data_r;
      tok_nxt.hit_cached = cached_r;
    end
    tok_nxt.count = tok_in.count + CNT_W'(valid_r);
    if (!valid_r && !tok_in.free_found) begin
      tok_nxt.free_found = 1'b1;
      tok_nxt.free_idx   = cell_idx;
    end
    if (older) begin
      tok_nxt.cand_found = 1'b1;
      tok_nxt.cand_idx   = cell_idx;
      tok_nxt.cand_stamp = stamp_r;
      tok_nxt.cand_key   = key_r;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  always_comb begin
    valid_nxt = valid_r;
    priority if (upd.clr_all) begin
      valid_nxt = 1'b0;
    end else if (upd.wr_en && (upd.wr_idx == cell_idx)) begin
      valid_nxt = 1'b1;
    end else if (upd.inv_en && (upd.inv_idx == cell_idx)) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!upd.clr_all && upd.wr_en && (upd.wr_idx == cell_idx)) begin
      key_r    <= upd.key;
      data_r   <= upd.data;
      cached_r <= upd.cached;
      stamp_r  <= upd.stamp;
    end else if (upd.touch_en && (upd.touch_idx == cell_idx)) begin
      stamp_r  <= upd.stamp;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== hw/rtl/lkc_ctrl.sv =====
module lkc_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_func,
  input  logic [31:0]                 in_key_hash,
  input  logic [31:0]                 in_entry_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_hit,
  output logic [31:0]                 out_data_out,
  output logic                        out_cached_mark,
  output logic                        out_evicted,
  output logic [31:0]                 out_evicted_hash,
  output logic                        out_dup_error,
  input  logic [4:0]                  entry_limit,
  input  logic                        keep_data,
  output logic [lkc_pkg::KEY_W-1:0]   req_key,
  output lkc_pkg::tok_t               tok_init,
  input  lkc_pkg::tok_t               tok_last,
  output lkc_pkg::upd_t               upd
);
  import lkc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_DONE  = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic [1:0]         func_r;
  logic [KEY_W-1:0]   key_r;
  logic [DATA_W-1:0]  data_r;
  logic [STAMP_W-1:0] stamp_r, stamp_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               hit_r, cached_r, evicted_r, dup_r;
  logic [31:0]        data_out_r, evicted_hash_r;
  logic               accept, finish, slot_free;
  logic               evict;
  logic [IDX_W-1:0]   put_idx;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign finish    = (state_r == ST_DONE) && slot_free;

  assign req_key = key_r;

  always_comb begin
    tok_init            = '0;
    tok_init.cand_stamp = stamp_r;
    tok_init.cand_key   = key_r;
  end

  assign evict = (32'(tok_last.count) >= 32'(entry_limit)) ||
                 (32'(tok_last.count) >= 32'(CAPACITY));

  // New entry takes the lowest free slot once the victim is gone.
  always_comb begin
    put_idx = tok_last.free_idx;
    if (evict && tok_last.cand_found &&
        (!tok_last.free_found || (tok_last.cand_idx < tok_last.free_idx))) begin
      put_idx = tok_last.cand_idx;
    end
  end

  always_comb begin
    upd           = '0;
    upd.key       = key_r;
    upd.data      = data_r;
    upd.cached    = !keep_data;
    upd.stamp     = stamp_r;
    upd.wr_idx    = put_idx;
    upd.inv_idx   = tok_last.cand_idx;
    upd.touch_idx = tok_last.hit_idx;
    stamp_nxt     = stamp_r;
    if (finish) begin
      unique case (func_r)
        FUNC_LOOKUP: begin
          if (tok_last.hit) begin
            upd.touch_en = 1'b1;
            stamp_nxt    = stamp_r + 1'b1;
          end
        end
        FUNC_INSERT: begin
          if (!tok_last.hit) begin
            stamp_nxt = stamp_r + 1'b1;
            if (!evict) begin
              upd.wr_en = 1'b1;
            end else if (tok_last.cand_found) begin
              upd.inv_en = 1'b1;
              upd.wr_en  = 1'b1;
            end
          end
        end
        FUNC_CLEAR: upd.clr_all = 1'b1;
        FUNC_NOP:   ;
        default:    ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cnt_nxt = '0;
          if ((in_func == FUNC_LOOKUP) || (in_func == FUNC_INSERT)) begin
            state_nxt = ST_SWEEP;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SWEEP: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == IDX_W'(CAPACITY - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (finish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      stamp_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      stamp_r     <= stamp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the request for the length of the sweep.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      key_r  <= in_key_hash;
      data_r <= DATA_W'(in_entry_data);
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      hit_r          <= 1'b0;
      data_out_r     <= '0;
      cached_r       <= 1'b0;
      evicted_r      <= 1'b0;
      evicted_hash_r <= '0;
      dup_r          <= 1'b0;
      if ((func_r == FUNC_LOOKUP) && tok_last.hit) begin
        hit_r      <= 1'b1;
        data_out_r <= 32'(tok_last.hit_data);
        cached_r   <= tok_last.hit_cached;
      end
      if (func_r == FUNC_INSERT) begin
        if (tok_last.hit) begin
          dup_r <= 1'b1;
        end else if (evict) begin
          evicted_r      <= 1'b1;
          evicted_hash_r <= tok_last.cand_key;
        end
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = hit_r;
  assign out_data_out     = data_out_r;
  assign out_cached_mark  = cached_r;
  assign out_evicted      = evicted_r;
  assign out_evicted_hash = evicted_hash_r;
  assign out_dup_error    = dup_r;

endmodule
